>>> rtl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/rsb_pkg.sv
package rsb_pkg;

    localparam int COORD_W            = 24;
    localparam int DIST_W             = 25;
    localparam int FRAC_W             = 16;
    localparam int HEIGHT_WIDTH_DEF   = 24;
    localparam int GATE_FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W          = 4;

    localparam logic [FRAC_W:0]   FRAC_ONE      = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [DIST_W-1:0] SPAN_FULL_RST = DIST_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCUS_X      = 4'd0,
        CFG_FOCUS_Z      = 4'd1,
        CFG_BASE_HEIGHT  = 4'd2,
        CFG_FLOOR_FRAC   = 4'd3,
        CFG_BROAD_START  = 4'd4,
        CFG_BROAD_FULL   = 4'd5,
        CFG_DETAIL_START = 4'd6,
        CFG_DETAIL_FULL  = 4'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        GM_ZERO = 2'd0,
        GM_ONE  = 2'd1,
        GM_CALC = 2'd2
    } t_gate_mode;

endpackage

>>> rtl/rsb_gate.sv
module rsb_gate #(
    parameter int GATE_FRAC_BITS = rsb_pkg::GATE_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic [GATE_FRAC_BITS+3:0]   i_en,
    input  logic [rsb_pkg::DIST_W-1:0]  i_dist,
    input  logic [rsb_pkg::DIST_W-1:0]  i_start,
    input  logic [rsb_pkg::DIST_W-1:0]  i_full,
    output logic [GATE_FRAC_BITS:0]     o_gate
);

    localparam int G  = GATE_FRAC_BITS;
    localparam int DW = rsb_pkg::DIST_W;
    localparam logic [G:0]   ONE     = {1'b1, {G{1'b0}}};
    localparam logic [G+4:0] TEN_ONE = (G+5)'(10) << G;

    logic [DW-1:0]       r_rem  [0:G];
    logic [DW-1:0]       r_span [0:G];
    logic [G-1:0]        r_q    [0:G];
    rsb_pkg::t_gate_mode r_mode [0:G];
    rsb_pkg::t_gate_mode n_mode;

    always_comb begin
        if (i_full <= i_start) begin
            n_mode = (i_dist >= i_start) ? rsb_pkg::GM_ONE : rsb_pkg::GM_ZERO;
        end else if (i_dist <= i_start) begin
            n_mode = rsb_pkg::GM_ZERO;
        end else if (i_dist >= i_full) begin
            n_mode = rsb_pkg::GM_ONE;
        end else begin
            n_mode = rsb_pkg::GM_CALC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0]  <= i_dist - i_start;
            r_span[0] <= i_full - i_start;
            r_q[0]    <= '0;
            r_mode[0] <= n_mode;
        end
    end

    // Restoring divide, one quotient bit per stage.
    for (genvar k = 1; k <= G; k++) begin : g_div
        logic [DW:0] w_r2;
        logic [DW:0] w_diff;
        logic        w_ge;
        assign w_r2   = {r_rem[k-1], 1'b0};
        assign w_diff = w_r2 - {1'b0, r_span[k-1]};
        assign w_ge   = (w_r2 >= {1'b0, r_span[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= w_ge ? w_diff[DW-1:0] : w_r2[DW-1:0];
                r_span[k] <= r_span[k-1];
                r_q[k]    <= {r_q[k-1][G-2:0], w_ge};
                r_mode[k] <= r_mode[k-1];
            end
        end
    end

    logic [G-1:0]        r_t;
    logic [2*G-1:0]      r_tt;
    rsb_pkg::t_gate_mode r_mode_a;
    logic [G-1:0]        r_t3;
    logic [G+3:0]        r_p;
    rsb_pkg::t_gate_mode r_mode_b;
    logic [G:0]          r_gate;

    always_ff @(posedge i_clk) begin
        if (i_en[G+1]) begin
            r_t      <= r_q[G];
            r_tt     <= r_q[G] * r_q[G];
            r_mode_a <= r_mode[G];
        end
    end

    logic [2*G-1:0] w_t3_full;
    logic [2*G+2:0] w_six;
    logic [G+4:0]   w_p;
    assign w_t3_full = r_tt[2*G-1:G] * r_t;
    assign w_six     = {r_tt, 2'b00} + {1'b0, r_tt, 1'b0};
    assign w_p       = {2'b00, w_six[2*G+2:G]} + TEN_ONE
                     - ({1'b0, r_t, 4'b0000} - {5'b00000, r_t});

    always_ff @(posedge i_clk) begin
        if (i_en[G+2]) begin
            r_t3     <= w_t3_full[2*G-1:G];
            r_p      <= w_p[G+3:0];
            r_mode_b <= r_mode_a;
        end
    end

    logic [2*G+3:0] w_prod;
    logic [G+3:0]   w_r;
    logic [G:0]     n_gate;
    assign w_prod = r_t3 * r_p;
    assign w_r    = w_prod[2*G+3:G];

    always_comb begin
        case (r_mode_b)
            rsb_pkg::GM_ZERO: n_gate = '0;
            rsb_pkg::GM_ONE:  n_gate = ONE;
            default:          n_gate = (w_r > {3'b000, ONE}) ? ONE : w_r[G:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[G+3]) begin
            r_gate <= n_gate;
        end
    end

    assign o_gate = r_gate;

endmodule

>>> rtl/radial_smootherstep_height_blend_top.sv
// Radial smootherstep height blend.
// Input stream s_axis carries one query per transaction: world position and
// four height samples in tdata, the detail-taken flag in tuser.
// Output stream m_axis returns one result per query, in order: blended,
// floor and detail heights, radial distance and both gate weights.
// Configuration registers are written over the cfg channel (index, data);
// write them only while no query is in flight.
// The pipeline holds three front stages (offsets, squares and floor scaling),
// 25 square-root stages with one root bit each, GATE_FRAC_BITS + 4 gate
// stages (a setup stage, one quotient bit per stage of the divider, then
// the polynomial) and two blend stages.
// Throughput is one query per cycle. Every stage carries a valid bit and
// moves whenever the stage after it is empty or moving, so bubbles close up
// and a stalled receiver holds its result while upstream stages keep filling.
// Reset clears the valid bits and loads the register defaults; no result is
// produced until a query arrives.
module radial_smootherstep_height_blend_top #(
    parameter int HEIGHT_WIDTH   = rsb_pkg::HEIGHT_WIDTH_DEF,
    parameter int GATE_FRAC_BITS = rsb_pkg::GATE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // query x, query z, unfiltered sample, structure sample, detail sample,
    // floor sample; zero padded to bytes
    input  logic [((2*rsb_pkg::COORD_W+4*HEIGHT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // detail_taken
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // blended height, scaled floor, detail used, distance from focus,
    // broad weight, detail weight; zero padded to bytes
    output logic [((3*HEIGHT_WIDTH+rsb_pkg::DIST_W+2*GATE_FRAC_BITS+2+7)/8)*8-1:0]
                                            m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [((HEIGHT_WIDTH > rsb_pkg::DIST_W) ? HEIGHT_WIDTH : rsb_pkg::DIST_W)-1:0]
                                            i_cfg_data
);

    localparam int HW    = HEIGHT_WIDTH;
    localparam int G     = GATE_FRAC_BITS;
    localparam int CW    = rsb_pkg::COORD_W;
    localparam int DW    = rsb_pkg::DIST_W;
    localparam int FW    = rsb_pkg::FRAC_W;
    localparam int RADW  = 2 * DW;
    localparam int REMW  = DW + 2;
    localparam int S_SQ  = 3;
    localparam int GS    = S_SQ + DW;
    localparam int NG    = G + 4;
    localparam int BL0   = GS + NG;
    localparam int NS    = BL0 + 2;
    localparam int NSB   = BL0 - S_SQ;
    localparam int FPW   = HW + 19;
    localparam int AW    = G + HW + 4;

    localparam int OFF_WX  = 0;
    localparam int OFF_WZ  = CW;
    localparam int OFF_SRC = 2 * CW;
    localparam int OFF_STR = 2 * CW + HW;
    localparam int OFF_DET = 2 * CW + 2 * HW;
    localparam int OFF_FL  = 2 * CW + 3 * HW;

    localparam int OFF_BL  = 0;
    localparam int OFF_FH  = HW;
    localparam int OFF_DH  = 2 * HW;
    localparam int OFF_DS  = 3 * HW;
    localparam int OFF_BG  = 3 * HW + DW;
    localparam int OFF_DG  = 3 * HW + DW + G + 1;

    // ---------------- configuration ----------------
    logic signed [CW-1:0] r_focus_x;
    logic signed [CW-1:0] r_focus_z;
    logic signed [HW-1:0] r_base;
    logic [FW:0]          r_frac;
    logic [DW-1:0]        r_bs;
    logic [DW-1:0]        r_bf;
    logic [DW-1:0]        r_ds;
    logic [DW-1:0]        r_df;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus_x <= '0;
            r_focus_z <= '0;
            r_base    <= '0;
            r_frac    <= rsb_pkg::FRAC_ONE;
            r_bs      <= '0;
            r_bf      <= rsb_pkg::SPAN_FULL_RST;
            r_ds      <= '0;
            r_df      <= rsb_pkg::SPAN_FULL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rsb_pkg::t_cfg_idx'(i_cfg_index))
                rsb_pkg::CFG_FOCUS_X:      r_focus_x <= i_cfg_data[CW-1:0];
                rsb_pkg::CFG_FOCUS_Z:      r_focus_z <= i_cfg_data[CW-1:0];
                rsb_pkg::CFG_BASE_HEIGHT:  r_base    <= i_cfg_data[HW-1:0];
                rsb_pkg::CFG_FLOOR_FRAC:   r_frac    <= i_cfg_data[FW:0];
                rsb_pkg::CFG_BROAD_START:  r_bs      <= i_cfg_data[DW-1:0];
                rsb_pkg::CFG_BROAD_FULL:   r_bf      <= i_cfg_data[DW-1:0];
                rsb_pkg::CFG_DETAIL_START: r_ds      <= i_cfg_data[DW-1:0];
                rsb_pkg::CFG_DETAIL_FULL:  r_df      <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage flow control ----------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage A: offsets ----------------
    logic signed [CW-1:0] w_wx, w_wz;
    logic signed [HW-1:0] w_src, w_str, w_det, w_fl;
    assign w_wx  = s_axis_tdata[OFF_WX  +: CW];
    assign w_wz  = s_axis_tdata[OFF_WZ  +: CW];
    assign w_src = s_axis_tdata[OFF_SRC +: HW];
    assign w_str = s_axis_tdata[OFF_STR +: HW];
    assign w_det = s_axis_tdata[OFF_DET +: HW];
    assign w_fl  = s_axis_tdata[OFF_FL  +: HW];

    logic signed [DW-1:0] r_a_dx, r_a_dz;
    logic signed [HW:0]   r_a_dfl;
    logic signed [HW-1:0] r_a_str, r_a_dh;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a_dx  <= {w_wx[CW-1], w_wx} - {r_focus_x[CW-1], r_focus_x};
            r_a_dz  <= {w_wz[CW-1], w_wz} - {r_focus_z[CW-1], r_focus_z};
            r_a_dfl <= {w_fl[HW-1], w_fl} - {r_base[HW-1], r_base};
            r_a_str <= w_str;
            r_a_dh  <= s_axis_tuser ? w_det : w_src;
        end
    end

    // ---------------- stage B: squares, floor product ----------------
    logic signed [RADW-1:0] w_sqx, w_sqz;
    logic [FW:0]            w_frac;
    logic signed [FPW-1:0]  w_fp;
    assign w_sqx  = r_a_dx * r_a_dx;
    assign w_sqz  = r_a_dz * r_a_dz;
    assign w_frac = (r_frac > rsb_pkg::FRAC_ONE) ? rsb_pkg::FRAC_ONE : r_frac;
    assign w_fp   = $signed({1'b0, w_frac}) * r_a_dfl;

    logic [RADW-2:0]       r_b_sqx, r_b_sqz;
    logic signed [FPW-1:0] r_b_fp;
    logic signed [HW-1:0]  r_b_str, r_b_dh;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_b_sqx <= w_sqx[RADW-2:0];
            r_b_sqz <= w_sqz[RADW-2:0];
            r_b_fp  <= w_fp;
            r_b_str <= r_a_str;
            r_b_dh  <= r_a_dh;
        end
    end

    // ---------------- stage C: radicand, floor height ----------------
    logic signed [FPW-1:0] w_fsum;
    logic                  w_fok;
    logic signed [HW-1:0]  w_fh;
    assign w_fsum = $signed({{(FPW-HW){r_base[HW-1]}}, r_base}) + (r_b_fp >>> FW);
    assign w_fok  = (w_fsum[FPW-1:HW-1] == {(FPW-HW+1){w_fsum[FPW-1]}});
    assign w_fh   = w_fok ? w_fsum[HW-1:0]
                  : (w_fsum[FPW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}});

    logic [RADW-1:0]      r_c_sum;
    logic signed [HW-1:0] r_c_fh, r_c_str, r_c_dh;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_c_sum <= {1'b0, r_b_sqx} + {1'b0, r_b_sqz};
            r_c_fh  <= w_fh;
            r_c_str <= r_b_str;
            r_c_dh  <= r_b_dh;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic [RADW-1:0] r_rad  [0:DW-1];
    logic [REMW-1:0] r_rem  [0:DW-1];
    logic [DW-1:0]   r_root [0:DW-1];

    for (genvar i = 0; i < DW; i++) begin : g_sqrt
        logic [RADW-1:0] w_rad_in;
        logic [REMW-1:0] w_rem_in;
        logic [DW-1:0]   w_root_in;
        logic [REMW+1:0] w_cur;
        logic [REMW+1:0] w_trial;
        logic            w_ge;
        logic [REMW+1:0] w_sub;
        if (i == 0) begin : g_first
            assign w_rad_in  = r_c_sum;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rad_in  = r_rad[i-1];
            assign w_rem_in  = r_rem[i-1];
            assign w_root_in = r_root[i-1];
        end
        assign w_cur   = {w_rem_in, w_rad_in[RADW-1 -: 2]};
        assign w_trial = {2'b00, w_root_in, 2'b01};
        assign w_ge    = (w_cur >= w_trial);
        assign w_sub   = w_cur - w_trial;
        always_ff @(posedge i_clk) begin
            if (w_en[S_SQ+i]) begin
                r_rad[i]  <= {w_rad_in[RADW-3:0], 2'b00};
                r_rem[i]  <= w_ge ? w_sub[REMW-1:0] : w_cur[REMW-1:0];
                r_root[i] <= {w_root_in[DW-2:0], w_ge};
            end
        end
    end

    // ---------------- height sideband through root and gate stages ----------------
    logic signed [HW-1:0] r_sb_fh  [0:NSB-1];
    logic signed [HW-1:0] r_sb_dh  [0:NSB-1];
    logic signed [HW:0]   r_sb_d1  [0:NSB-1];
    logic signed [HW:0]   r_sb_d2  [0:NSB-1];

    for (genvar j = 0; j < NSB; j++) begin : g_sb
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en[S_SQ]) begin
                    r_sb_fh[0] <= r_c_fh;
                    r_sb_dh[0] <= r_c_dh;
                    r_sb_d1[0] <= {r_c_str[HW-1], r_c_str} - {r_c_fh[HW-1], r_c_fh};
                    r_sb_d2[0] <= {r_c_dh[HW-1], r_c_dh} - {r_c_str[HW-1], r_c_str};
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_en[S_SQ+j]) begin
                    r_sb_fh[j] <= r_sb_fh[j-1];
                    r_sb_dh[j] <= r_sb_dh[j-1];
                    r_sb_d1[j] <= r_sb_d1[j-1];
                    r_sb_d2[j] <= r_sb_d2[j-1];
                end
            end
        end
    end

    // ---------------- gates ----------------
    logic [DW-1:0] w_dist;
    logic [G:0]    w_bg, w_dg;
    assign w_dist = r_root[DW-1];

    rsb_gate #(.GATE_FRAC_BITS(G)) u_broad (
        .i_clk   (i_clk),
        .i_en    (w_en[GS +: NG]),
        .i_dist  (w_dist),
        .i_start (r_bs),
        .i_full  (r_bf),
        .o_gate  (w_bg)
    );

    rsb_gate #(.GATE_FRAC_BITS(G)) u_detail (
        .i_clk   (i_clk),
        .i_en    (w_en[GS +: NG]),
        .i_dist  (w_dist),
        .i_start (r_ds),
        .i_full  (r_df),
        .o_gate  (w_dg)
    );

    logic [DW-1:0] r_gd [0:NG-1];
    for (genvar j = 0; j < NG; j++) begin : g_gd
        always_ff @(posedge i_clk) begin
            if (w_en[GS+j]) begin
                r_gd[j] <= (j == 0) ? w_dist : r_gd[(j == 0) ? 0 : j-1];
            end
        end
    end

    // ---------------- blend stage 0: weighted differences ----------------
    logic signed [G+HW+2:0] w_m1, w_m2;
    assign w_m1 = $signed({1'b0, w_bg}) * r_sb_d1[NSB-1];
    assign w_m2 = $signed({1'b0, w_dg}) * r_sb_d2[NSB-1];

    logic signed [G+HW+2:0] r_m1, r_m2;
    logic signed [HW-1:0]   r_p_fh, r_p_dh;
    logic [DW-1:0]          r_p_dist;
    logic [G:0]             r_p_bg, r_p_dg;

    always_ff @(posedge i_clk) begin
        if (w_en[BL0]) begin
            r_m1     <= w_m1;
            r_m2     <= w_m2;
            r_p_fh   <= r_sb_fh[NSB-1];
            r_p_dh   <= r_sb_dh[NSB-1];
            r_p_dist <= r_gd[NG-1];
            r_p_bg   <= w_bg;
            r_p_dg   <= w_dg;
        end
    end

    // ---------------- blend stage 1: sum, floor shift, saturate ----------------
    logic signed [AW-1:0] w_acc, w_sh;
    logic                 w_bok;
    logic signed [HW-1:0] w_blend;
    assign w_acc   = ($signed({{(AW-HW){r_p_fh[HW-1]}}, r_p_fh}) <<< G)
                   + {r_m1[G+HW+2], r_m1} + {r_m2[G+HW+2], r_m2};
    assign w_sh    = w_acc >>> G;
    assign w_bok   = (w_sh[AW-1:HW-1] == {(AW-HW+1){w_sh[AW-1]}});
    assign w_blend = w_bok ? w_sh[HW-1:0]
                   : (w_sh[AW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}});

    logic signed [HW-1:0] r_o_bl, r_o_fh, r_o_dh;
    logic [DW-1:0]        r_o_dist;
    logic [G:0]           r_o_bg, r_o_dg;

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_o_bl   <= w_blend;
            r_o_fh   <= r_p_fh;
            r_o_dh   <= r_p_dh;
            r_o_dist <= r_p_dist;
            r_o_bg   <= r_p_bg;
            r_o_dg   <= r_p_dg;
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[OFF_BL +: HW]  = r_o_bl;
        m_axis_tdata[OFF_FH +: HW]  = r_o_fh;
        m_axis_tdata[OFF_DH +: HW]  = r_o_dh;
        m_axis_tdata[OFF_DS +: DW]  = r_o_dist;
        m_axis_tdata[OFF_BG +: G+1] = r_o_bg;
        m_axis_tdata[OFF_DG +: G+1] = r_o_dg;
    end

    // ---------------- checks ----------------
    logic w_in_acc;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_gate_range, i_clk, i_rst_n, m_axis_tvalid, (r_o_bg <= {1'b1, {G{1'b0}}}) && (r_o_dg <= {1'b1, {G{1'b0}}}))
    `ASSERT_IMPLY(a_empty_ready, i_clk, i_rst_n, r_v == '0, s_axis_tready)
    `ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, w_in_acc, r_v[0])
    `ASSERT_NEXT(a_stall_holds_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready && r_v[NS-2], r_v[NS-2] && r_v[NS-1])

endmodule

>>> sim/tb_radial_smootherstep_height_blend_top.sv
`timescale 1ns / 1ps

module tb_radial_smootherstep_height_blend_top;

    localparam int HW      = 24;
    localparam int GB      = 16;
    localparam int CW      = rsb_pkg::COORD_W;
    localparam int DW      = rsb_pkg::DIST_W;
    localparam int FW      = rsb_pkg::FRAC_W;
    localparam int IW      = rsb_pkg::CFG_IDX_W;
    localparam int IN_W    = ((2*CW + 4*HW + 7)/8)*8;
    localparam int OUT_W   = ((3*HW + DW + 2*GB + 2 + 7)/8)*8;
    localparam int CFG_W   = (HW > DW) ? HW : DW;
    localparam int LATENCY = GB + 34;
    localparam logic [IW-1:0] CFG_UNUSED_A = 4'd9;
    localparam logic [IW-1:0] CFG_UNUSED_B = 4'd15;
    localparam longint HMAX = (64'sd1 <<< (HW-1)) - 1;
    localparam longint HMIN = -(64'sd1 <<< (HW-1));

    typedef struct packed {
        logic [GB:0]   dgate;
        logic [GB:0]   bgate;
        logic [DW-1:0] rdist;
        logic [HW-1:0] detail_h;
        logic [HW-1:0] floor_h;
        logic [HW-1:0] blended;
    } t_blend_result;

    class t_height_scoreboard;
        longint        fx, fz, base, frac, bstart, bfull, dstart, dfull;
        t_blend_result expected_q[$];
        int            mismatches;
        int            results_seen;

        function new();
            fx = 0; fz = 0; base = 0; frac = 65536;
            bstart = 0; bfull = 256; dstart = 0; dfull = 256;
            mismatches = 0; results_seen = 0;
        endfunction

        function longint sx(logic [CFG_W-1:0] v, int w);
            longint r;
            r = longint'(v) & ((64'sd1 <<< w) - 1);
            if (r[w-1]) r = r - (64'sd1 <<< w);
            return r;
        endfunction

        function void write_reg(logic [IW-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                rsb_pkg::CFG_FOCUS_X:      fx = sx(v, CW);
                rsb_pkg::CFG_FOCUS_Z:      fz = sx(v, CW);
                rsb_pkg::CFG_BASE_HEIGHT:  base = sx(v, HW);
                rsb_pkg::CFG_FLOOR_FRAC:   frac = longint'(v[FW:0]);
                rsb_pkg::CFG_BROAD_START:  bstart = longint'(v[DW-1:0]);
                rsb_pkg::CFG_BROAD_FULL:   bfull = longint'(v[DW-1:0]);
                rsb_pkg::CFG_DETAIL_START: dstart = longint'(v[DW-1:0]);
                rsb_pkg::CFG_DETAIL_FULL:  dfull = longint'(v[DW-1:0]);
                default: ;
            endcase
        endfunction

        function longint root_floor(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return longint'(res);
        endfunction

        function longint smootherstep(longint st, longint fu, longint d);
            longint one, t, t2, t3, p, r;
            one = 64'sd1 <<< GB;
            // empty span acts as a step at the start distance
            if (fu <= st) return (d >= st) ? one : 0;
            if (d <= st) return 0;
            if (d >= fu) return one;
            t = ((d - st) <<< GB) / (fu - st);
            if (t > one) t = one;
            t2 = (t * t) >>> GB;
            t3 = (t2 * t) >>> GB;
            p = (6*t*t - 15*t*one + 10*one*one) >>> GB;
            r = (t3 * p) >>> GB;
            return (r > one) ? one : r;
        endfunction

        function longint clip_h(longint v);
            return (v > HMAX) ? HMAX : ((v < HMIN) ? HMIN : v);
        endfunction

        function void note(logic signed [CW-1:0] wx, logic signed [CW-1:0] wz,
                           logic signed [HW-1:0] src, logic signed [HW-1:0] str,
                           logic signed [HW-1:0] det, logic taken,
                           logic signed [HW-1:0] flr);
            longint        kf, dx, dz, d, fh, dh, bg, dg, acc;
            t_blend_result e;
            kf = (frac > 65536) ? 65536 : frac;
            fh = clip_h(base + ((kf * (longint'(flr) - base)) >>> FW));
            dh = taken ? longint'(det) : longint'(src);
            dx = longint'(wx) - fx;
            dz = longint'(wz) - fz;
            d = root_floor(longint'(dx*dx) + longint'(dz*dz));
            if (d > (64'sd1 <<< DW) - 1) d = (64'sd1 <<< DW) - 1;
            bg = smootherstep(bstart, bfull, d);
            dg = smootherstep(dstart, dfull, d);
            acc = (fh <<< GB) + bg * (longint'(str) - fh) + dg * (dh - longint'(str));
            e.blended  = HW'(clip_h(acc >>> GB));
            e.floor_h  = HW'(fh);
            e.detail_h = HW'(dh);
            e.rdist    = DW'(d);
            e.bgate    = (GB+1)'(bg);
            e.dgate    = (GB+1)'(dg);
            expected_q.push_back(e);
        endfunction

        function void report(string what, longint exp_v, longint act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d (0x%0h) got %0d (0x%0h)",
                         what, exp_v, exp_v, act_v, act_v);
        endfunction

        function void check(logic [OUT_W-1:0] raw);
            t_blend_result a, e;
            a = raw[$bits(t_blend_result)-1:0];
            results_seen++;
            if (expected_q.size() == 0) begin
                report("unexpected result", 0, longint'(a.blended));
                return;
            end
            e = expected_q.pop_front();
            if (a.blended !== e.blended)   report("blend", e.blended, a.blended);
            if (a.floor_h !== e.floor_h)   report("scaled floor", e.floor_h, a.floor_h);
            if (a.detail_h !== e.detail_h) report("detail used", e.detail_h, a.detail_h);
            if (a.rdist !== e.rdist)       report("distance", e.rdist, a.rdist);
            if (a.bgate !== e.bgate)       report("broad weight", e.bgate, a.bgate);
            if (a.dgate !== e.dgate)       report("detail weight", e.dgate, a.dgate);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IW-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    t_height_scoreboard sb = new();
    bit  calm = 1'b0;
    int  stall_left = 0;
    int  queries_sent = 0;
    int  cfg_writes = 0;

    radial_smootherstep_height_blend_top u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // receiver: alternate ready and stall stretches
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tdata[71:48],
                    s_axis_tdata[95:72], s_axis_tdata[119:96], s_axis_tuser,
                    s_axis_tdata[143:120]);
            queries_sent++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tdata);
    end

    task automatic send_query(logic [23:0] wx, logic [23:0] wz, logic [23:0] src,
                              logic [23:0] str, logic [23:0] det, logic taken,
                              logic [23:0] flr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({flr, det, str, src, wz, wx});
        s_axis_tuser  <= taken;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IW-1:0] idx, logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, v);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold until the pipe is empty, then let the latency pass
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_spans(logic [24:0] bs, logic [24:0] bf,
                             logic [24:0] ds, logic [24:0] df);
        write_reg(rsb_pkg::CFG_BROAD_START, bs);
        write_reg(rsb_pkg::CFG_BROAD_FULL, bf);
        write_reg(rsb_pkg::CFG_DETAIL_START, ds);
        write_reg(rsb_pkg::CFG_DETAIL_FULL, df);
    endtask

    function logic [23:0] rand_h();
        case ($urandom_range(0, 9))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'h000000;
            3, 4, 5: return 24'($signed($urandom_range(0, 131071)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    // coordinate near the focus so the gates see their whole span
    function logic [23:0] near(longint f, longint reach);
        return 24'(f + $signed($urandom_range(0, 2*reach)) - reach);
    endfunction

    task automatic random_query(longint reach);
        logic [23:0] wx, wz;
        if ($urandom_range(0, 9) < 8) begin
            wx = near(sb.fx, reach);
            wz = near(sb.fz, reach);
        end else begin
            wx = 24'($urandom);
            wz = 24'($urandom);
        end
        send_query(wx, wz, rand_h(), rand_h(), rand_h(), 1'($urandom), rand_h());
    endtask

    initial begin
        longint s, r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset defaults, field extremes
        calm = 1'b1;
        send_query(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b0,
                   24'h000000);
        send_query(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 1'b1,
                   24'h800000);
        send_query(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 1'b0,
                   24'h7fffff);
        send_query(24'h000080, 24'h000000, 24'h001234, 24'h000500, 24'hfff000, 1'b1,
                   24'h000100);
        send_query(24'h000100, 24'h000000, 24'hffffff, 24'h000200, 24'h000300, 1'b0,
                   24'hffff00);
        drain();

        // directed: focus and base at extremes, fraction above one, empty spans
        write_reg(rsb_pkg::CFG_FOCUS_X, 25'h07fffff);
        write_reg(rsb_pkg::CFG_FOCUS_Z, 25'h0800000);
        write_reg(rsb_pkg::CFG_BASE_HEIGHT, 25'h0800000);
        write_reg(rsb_pkg::CFG_FLOOR_FRAC, 25'h001ffff);
        write_reg(CFG_UNUSED_A, 25'h1ffffff);
        set_spans(25'd1000, 25'd1000, 25'd5000, 25'd10);
        send_query(24'h7fffff, 24'h800000, 24'h000000, 24'h7fffff, 24'h800000, 1'b1,
                   24'h7fffff);
        send_query(24'h7ffc17, 24'h800000, 24'h000010, 24'h000020, 24'h000030, 1'b0,
                   24'h000040);
        send_query(24'h7ffc18, 24'h800000, 24'h000010, 24'h000020, 24'h000030, 1'b1,
                   24'h000040);
        send_query(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 1'b1,
                   24'h800000);
        send_query(24'h7fe000, 24'h800000, 24'h800000, 24'h7fffff, 24'h000000, 1'b0,
                   24'h800000);
        drain();

        write_reg(rsb_pkg::CFG_FOCUS_X, 25'd0);
        write_reg(rsb_pkg::CFG_FOCUS_Z, 25'd0);
        write_reg(rsb_pkg::CFG_BASE_HEIGHT, 25'h07fffff);
        write_reg(rsb_pkg::CFG_FLOOR_FRAC, 25'd0);
        write_reg(CFG_UNUSED_B, 25'd77);
        set_spans(25'd0, 25'h1ffffff, 25'h1ffffff, 25'h1ffffff);
        send_query(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 1'b1,
                   24'h800000);
        send_query(24'h400000, 24'hc00000, 24'h000000, 24'h7fffff, 24'h800000, 1'b1,
                   24'h7fffff);
        send_query(24'h000000, 24'h000000, 24'h800000, 24'h000000, 24'h000000, 1'b0,
                   24'h800000);
        drain();

        write_reg(rsb_pkg::CFG_FLOOR_FRAC, 25'd65536);
        write_reg(rsb_pkg::CFG_BASE_HEIGHT, 25'd0);
        set_spans(25'd0, 25'd1, 25'd256, 25'd65536);
        for (int k = 0; k < 6; k++)
            send_query(24'(k * 16000), 24'(k * 7), 24'h7fffff, 24'h7fffff, 24'h800000,
                       1'(k), 24'h800000);
        drain();
        calm = 1'b0;

        // random phases, each with fresh registers
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(rsb_pkg::CFG_FOCUS_X, 25'($urandom));
            write_reg(rsb_pkg::CFG_FOCUS_Z, 25'($urandom));
            write_reg(rsb_pkg::CFG_BASE_HEIGHT, 25'(rand_h()));
            write_reg(rsb_pkg::CFG_FLOOR_FRAC,
                      (ph == 3) ? 25'd70000 : 25'($urandom_range(0, 65536)));
            r = 64'sd1 <<< $urandom_range(4, 20);
            s = $urandom_range(0, int'(r));
            if (ph == 5)
                set_spans(25'(s), 25'(s), 25'(s + r), 25'(s));
            else
                set_spans(25'(s), 25'(s + $urandom_range(1, int'(r))),
                          25'($urandom_range(0, int'(r))), 25'(r + $urandom_range(1, int'(r))));
            calm = (ph == 7);
            for (int n = 0; n < 53; n++)
                random_query(2 * r + 64);
            drain();
        end

        $display("covered %0d queries and %0d register writes over 14 register settings",
                 queries_sent, cfg_writes);
        $display("checked %0d results against the predicted heights, distances and gates",
                 sb.results_seen);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", sb.expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
